// ===== sv/adbkm_pkg.sv =====
// ----------------------------------------------------------------------------
// adbkm_pkg
// shared types and constants of the keyboard and mouse bus responder
// ----------------------------------------------------------------------------
package adbkm_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_HOST  = 2'd0,
    KIND_MOUSE = 2'd1,
    KIND_KBD   = 2'd2
  } cmd_kind_e;

  // bus addresses of the two devices
  localparam logic [3:0] MOUSE_ADDR = 4'h3;
  localparam logic [3:0] KBD_ADDR   = 4'h2;

  // command and register nibble of a host byte
  localparam logic [3:0] SUB_TALK0 = 4'hC;
  localparam logic [3:0] SUB_TALK2 = 4'hE;
  localparam logic [3:0] SUB_TALK3 = 4'hF;

  localparam logic [15:0] KBD_REG3_WORD   = 16'h4200;
  localparam logic [7:0]  KEY_LOW_FILL    = 8'hFF;
  localparam logic [7:0]  KEY_UP_BIT      = 8'h80;
  localparam logic [15:0] SKIP_WINDOW_RST = 16'd90;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  host_byte;
    logic [15:0] report_word;
    logic        invalid_flag;
    logic [7:0]  previous_key;
    logic [7:0]  modifier_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        talk;
    logic [15:0] talk_word;
    logic        mouse_service_request;
    logic        keyboard_service_request;
    logic        keydown_dropped;
  } out_item_t;

endpackage

// ===== sv/adbkm_chan_if.sv =====
// ----------------------------------------------------------------------------
// adbkm_chan_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface adbkm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/adb_keyboard_mouse_responder.sv =====
// ----------------------------------------------------------------------------
// adb_keyboard_mouse_responder
// device side of a desktop bus: keyboard at address 2, mouse at address 3
// ----------------------------------------------------------------------------
//  channel      dir  handshake          carries
//  in_i         in   valid / ready      host byte, mouse or keyboard report
//  out_o        out  valid / ready      reply word, service flags, drop flag
//  cfg_we_i     in   write enable only  hold-off window length in ms
//
//  one item per cycle sustained while the result side is not stalled; each item
//  passes through the input register and then sits in the result register
//  the device state is updated in the same cycle the result is registered
//  a stalled result register holds and the input register fills behind it
//  reset clears all device state and sets the window to 90 ms
// ----------------------------------------------------------------------------
module adb_keyboard_mouse_responder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  adbkm_chan_if.sink           in_i,
  adbkm_chan_if.source         out_o
);

  // hold-off window register
  logic [15:0] window_q;

  // input register
  logic                  stage_valid_q;
  adbkm_pkg::in_item_t   stage_q;

  // result register
  logic                  out_valid_q;
  adbkm_pkg::out_item_t  out_q;

  adbkm_pkg::out_item_t  result;
  logic                  advance;
  logic                  in_ready;
  logic                  in_fire;
  logic                  step;

  // the result register moves when empty or when its item is taken
  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !stage_valid_q || advance;
  assign in_fire  = in_i.valid && in_ready;
  // an item in the input register is worked on as it moves to the result
  assign step     = stage_valid_q && advance;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= adbkm_pkg::SKIP_WINDOW_RST;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_fire) begin
      stage_valid_q <= 1'b1;
    end else if (advance) begin
      stage_valid_q <= 1'b0;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_q <= in_i.payload;
    end
  end

  adbkm_devices u_devices (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stage_q),
    .window_i (window_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stage_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

`ifndef SYNTH
  // a dropped keydown never comes with a reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.keydown_dropped && out_q.talk))
    else $error("keydown dropped and reply sent together");

  // no reply means a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.talk) |-> (out_q.talk_word == 16'h0000))
    else $error("reply word not zero without a reply");

  // full input register behind a stalled result blocks new items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && out_valid_q && !out_o.ready) |-> !in_ready)
    else $error("input accepted while both registers are full");

  // an item worked on always shows up in the result register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("worked item lost before the result register");
`endif

endmodule

// ===== sv/adbkm_devices.sv =====
// ----------------------------------------------------------------------------
// adbkm_devices
// device state of keyboard and mouse, updated by one item per step
// ----------------------------------------------------------------------------
module adbkm_devices (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  adbkm_pkg::in_item_t  item_i,
  input  logic [15:0]          window_i,
  output adbkm_pkg::out_item_t result_o
);

  logic        mouse_pending_q, mouse_pending_d;
  logic [15:0] mouse_word_q, mouse_word_d;
  logic        mouse_srq_q, mouse_srq_d;
  logic        kbd_pending_q, kbd_pending_d;
  logic [15:0] kbd_word_q, kbd_word_d;
  logic        kbd_invalid_q, kbd_invalid_d;
  logic [7:0]  kbd_previous_q, kbd_previous_d;
  logic        kbd_srq_q, kbd_srq_d;
  logic [7:0]  modifiers_q, modifiers_d;
  logic [31:0] skip_stamp_q, skip_stamp_d;

  logic [3:0]  addr;
  logic [3:0]  sub;
  logic [31:0] elapsed;
  logic [7:0]  key_up;
  logic        talk;
  logic [15:0] word;
  logic        dropped;

  assign addr    = item_i.host_byte[7:4];
  assign sub     = item_i.host_byte[3:0];
  assign elapsed = item_i.now_ms - skip_stamp_q;
  assign key_up  = kbd_previous_q | adbkm_pkg::KEY_UP_BIT;

  always_comb begin
    mouse_pending_d = mouse_pending_q;
    mouse_word_d    = mouse_word_q;
    mouse_srq_d     = mouse_srq_q;
    kbd_pending_d   = kbd_pending_q;
    kbd_word_d      = kbd_word_q;
    kbd_invalid_d   = kbd_invalid_q;
    kbd_previous_d  = kbd_previous_q;
    kbd_srq_d       = kbd_srq_q;
    modifiers_d     = modifiers_q;
    skip_stamp_d    = skip_stamp_q;
    talk            = 1'b0;
    word            = 16'h0000;
    dropped         = 1'b0;

    case (item_i.command)
      adbkm_pkg::KIND_MOUSE: begin
        mouse_word_d    = item_i.report_word;
        mouse_pending_d = 1'b1;
      end
      adbkm_pkg::KIND_KBD: begin
        kbd_word_d     = item_i.report_word;
        kbd_pending_d  = 1'b1;
        kbd_invalid_d  = item_i.invalid_flag;
        kbd_previous_d = item_i.previous_key;
        modifiers_d    = item_i.modifier_byte;
      end
      adbkm_pkg::KIND_HOST: begin
        // mouse first
        if (addr == adbkm_pkg::MOUSE_ADDR) begin
          if (sub == adbkm_pkg::SUB_TALK0 && mouse_pending_q) begin
            talk            = 1'b1;
            word            = mouse_word_q;
            mouse_pending_d = 1'b0;
            mouse_srq_d     = 1'b0;
          end
        end else if (mouse_pending_q) begin
          mouse_srq_d = 1'b1;
        end

        if (addr == adbkm_pkg::KBD_ADDR) begin
          case (sub)
            adbkm_pkg::SUB_TALK0: begin
              if (kbd_pending_q) begin
                if (kbd_invalid_q) begin
                  // replacement key-up, opens the hold-off window
                  kbd_invalid_d  = 1'b0;
                  kbd_previous_d = key_up;
                  kbd_word_d     = {key_up, adbkm_pkg::KEY_LOW_FILL};
                  skip_stamp_d   = item_i.now_ms;
                  kbd_srq_d      = 1'b0;
                  kbd_pending_d  = 1'b0;
                  talk           = 1'b1;
                  word           = {key_up, adbkm_pkg::KEY_LOW_FILL};
                end else if (elapsed < {16'h0000, window_i}) begin
                  kbd_pending_d = 1'b0;
                  dropped       = 1'b1;
                end else begin
                  kbd_srq_d     = 1'b0;
                  kbd_pending_d = 1'b0;
                  talk          = 1'b1;
                  word          = kbd_word_q;
                end
              end
            end
            adbkm_pkg::SUB_TALK2: begin
              talk = 1'b1;
              word = {modifiers_q, adbkm_pkg::KEY_LOW_FILL};
            end
            adbkm_pkg::SUB_TALK3: begin
              talk = 1'b1;
              word = adbkm_pkg::KBD_REG3_WORD;
            end
            default: ;
          endcase
        end else if (kbd_pending_q) begin
          kbd_srq_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.talk                     = talk;
    result_o.talk_word                = word;
    result_o.mouse_service_request    = mouse_srq_d;
    result_o.keyboard_service_request = kbd_srq_d;
    result_o.keydown_dropped          = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mouse_pending_q <= 1'b0;
      mouse_word_q    <= 16'h0000;
      mouse_srq_q     <= 1'b0;
      kbd_pending_q   <= 1'b0;
      kbd_word_q      <= 16'h0000;
      kbd_invalid_q   <= 1'b0;
      kbd_previous_q  <= 8'h00;
      kbd_srq_q       <= 1'b0;
      modifiers_q     <= 8'h00;
      skip_stamp_q    <= 32'h0000_0000;
    end else if (step_i) begin
      mouse_pending_q <= mouse_pending_d;
      mouse_word_q    <= mouse_word_d;
      mouse_srq_q     <= mouse_srq_d;
      kbd_pending_q   <= kbd_pending_d;
      kbd_word_q      <= kbd_word_d;
      kbd_invalid_q   <= kbd_invalid_d;
      kbd_previous_q  <= kbd_previous_d;
      kbd_srq_q       <= kbd_srq_d;
      modifiers_q     <= modifiers_d;
      skip_stamp_q    <= skip_stamp_d;
    end
  end

endmodule

// ===== verif/adb_keyboard_mouse_responder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adb_keyboard_mouse_responder_tb
// self-checking bench for the keyboard and mouse bus responder: a short run of
// hand-written items with known replies, then phases of random host traffic
// and reports under several hold-off windows. replies with no known value are
// checked against a cycle-free behavioural model of both devices kept inside the bench.
// ----------------------------------------------------------------------------
module adb_keyboard_mouse_responder_tb;

  // item kind that the block must pass over untouched
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  // addresses and commands besides those in the package
  localparam logic [3:0] OTHER_ADDR = 4'h0;
  localparam logic [3:0] FAR_ADDR   = 4'hF;
  localparam logic [3:0] SUB_RESET  = 4'h0;
  localparam logic [3:0] SUB_TALK1  = 4'hD;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 235;
  localparam int unsigned QUIET_PHASE     = 4;
  localparam int unsigned GAP_PERCENT     = 7;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct {
    adbkm_pkg::in_item_t  item;
    bit                   has_want;
    adbkm_pkg::out_item_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  adbkm_chan_if #(.payload_t(adbkm_pkg::in_item_t))  in_if ();
  adbkm_chan_if #(.payload_t(adbkm_pkg::out_item_t)) out_if ();

  adb_keyboard_mouse_responder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // model of both devices, updated as each item is accepted
  logic        ms_pending;
  logic [15:0] ms_word;
  logic        ms_srq;
  logic        kb_pending;
  logic [15:0] kb_word;
  logic        kb_invalid;
  logic [7:0]  kb_prev;
  logic        kb_srq;
  logic [7:0]  kb_mods;
  logic [31:0] hold_stamp;
  logic [15:0] hold_window;

  adbkm_pkg::out_item_t expected_replies[$];
  stim_row_t            dir_rows[$];
  logic [15:0]          window_plan[RANDOM_PHASES];
  logic [31:0]          clock_ms;
  bit                   gaps_on;
  int unsigned          mismatch_count;
  int unsigned          cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // a hung handshake ends the run here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("adb_keyboard_mouse_responder test failed");
    $finish;
  end

  // reply of the two devices to one item; moves the model state on
  function automatic adbkm_pkg::out_item_t predict_reply(input adbkm_pkg::in_item_t it);
    adbkm_pkg::out_item_t r;
    logic [3:0]           addr;
    logic [3:0]           sub;
    logic [31:0]          elapsed;
    logic                 send;
    r       = '0;
    addr    = it.host_byte[7:4];
    sub     = it.host_byte[3:0];
    elapsed = it.now_ms - hold_stamp;
    case (it.command)
      adbkm_pkg::KIND_MOUSE: begin
        ms_word    = it.report_word;
        ms_pending = 1'b1;
      end
      adbkm_pkg::KIND_KBD: begin
        kb_word    = it.report_word;
        kb_pending = 1'b1;
        kb_invalid = it.invalid_flag;
        kb_prev    = it.previous_key;
        kb_mods    = it.modifier_byte;
      end
      adbkm_pkg::KIND_HOST: begin
        // mouse is looked at first, then the keyboard
        if (addr == adbkm_pkg::MOUSE_ADDR) begin
          if (sub == adbkm_pkg::SUB_TALK0 && ms_pending) begin
            r.talk      = 1'b1;
            r.talk_word = ms_word;
            ms_pending  = 1'b0;
            ms_srq      = 1'b0;
          end
        end else if (ms_pending) begin
          ms_srq = 1'b1;
        end

        if (addr == adbkm_pkg::KBD_ADDR) begin
          if (sub == adbkm_pkg::SUB_TALK0) begin
            if (kb_pending) begin
              send = 1'b1;
              if (kb_invalid) begin
                // bad report goes out as a key-up and opens the hold-off
                kb_invalid = 1'b0;
                kb_prev    = kb_prev | adbkm_pkg::KEY_UP_BIT;
                kb_word    = {kb_prev, adbkm_pkg::KEY_LOW_FILL};
                hold_stamp = it.now_ms;
              end else if (elapsed < {16'd0, hold_window}) begin
                // keydown inside the window is thrown away, srq untouched
                kb_pending        = 1'b0;
                r.keydown_dropped = 1'b1;
                send              = 1'b0;
              end
              if (send) begin
                kb_srq      = 1'b0;
                kb_pending  = 1'b0;
                r.talk      = 1'b1;
                r.talk_word = kb_word;
              end
            end
          end else if (sub == adbkm_pkg::SUB_TALK2) begin
            r.talk      = 1'b1;
            r.talk_word = {kb_mods, adbkm_pkg::KEY_LOW_FILL};
          end else if (sub == adbkm_pkg::SUB_TALK3) begin
            r.talk      = 1'b1;
            r.talk_word = adbkm_pkg::KBD_REG3_WORD;
          end
        end else if (kb_pending) begin
          kb_srq = 1'b1;
        end
      end
      default: ;
    endcase
    r.mouse_service_request    = ms_srq;
    r.keyboard_service_request = kb_srq;
    return r;
  endfunction

  // every field random; builders below overwrite the ones that matter
  function automatic adbkm_pkg::in_item_t junk_item();
    adbkm_pkg::in_item_t it;
    it.command       = 2'($urandom());
    it.host_byte     = 8'($urandom());
    it.report_word   = 16'($urandom());
    it.invalid_flag  = 1'($urandom());
    it.previous_key  = 8'($urandom());
    it.modifier_byte = 8'($urandom());
    it.now_ms        = $urandom();
    return it;
  endfunction

  function automatic adbkm_pkg::in_item_t host_item(input logic [7:0] hb,
                                                    input logic [31:0] now);
    adbkm_pkg::in_item_t it;
    it           = junk_item();
    it.command   = adbkm_pkg::KIND_HOST;
    it.host_byte = hb;
    it.now_ms    = now;
    return it;
  endfunction

  function automatic adbkm_pkg::in_item_t mouse_item(input logic [15:0] w);
    adbkm_pkg::in_item_t it;
    it             = junk_item();
    it.command     = adbkm_pkg::KIND_MOUSE;
    it.report_word = w;
    return it;
  endfunction

  function automatic adbkm_pkg::in_item_t kbd_item(input logic [15:0] w, input logic inv,
                                                   input logic [7:0] prev,
                                                   input logic [7:0] mods);
    adbkm_pkg::in_item_t it;
    it               = junk_item();
    it.command       = adbkm_pkg::KIND_KBD;
    it.report_word   = w;
    it.invalid_flag  = inv;
    it.previous_key  = prev;
    it.modifier_byte = mods;
    return it;
  endfunction

  function automatic adbkm_pkg::out_item_t outcome(input logic t, input logic [15:0] w,
                                                   input logic m, input logic k,
                                                   input logic d);
    return adbkm_pkg::out_item_t'({t, w, m, k, d});
  endfunction

  // random traffic: device reports, host bytes that are mostly polls of the two devices, and the reserved kind
  function automatic adbkm_pkg::in_item_t random_item();
    adbkm_pkg::in_item_t it;
    int unsigned         roll;
    int unsigned         pick;
    it   = junk_item();
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    // time creeps forward in small steps so the window edge is hit often
    if ($urandom_range(49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(120);
    it.now_ms = clock_ms;
    if (roll < 15) begin
      it.command = adbkm_pkg::KIND_MOUSE;
    end else if (roll < 40) begin
      it.command      = adbkm_pkg::KIND_KBD;
      it.invalid_flag = ($urandom_range(99) < 30);
    end else if (roll < 97) begin
      it.command = adbkm_pkg::KIND_HOST;
      if (pick < 30)      it.host_byte = {adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0};
      else if (pick < 45) it.host_byte = {adbkm_pkg::MOUSE_ADDR, adbkm_pkg::SUB_TALK0};
      else if (pick < 55) it.host_byte = {adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK2};
      else if (pick < 62) it.host_byte = {adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK3};
      else if (pick < 85) it.host_byte = 8'($urandom());
      else it.host_byte = {($urandom_range(1) == 1) ? adbkm_pkg::KBD_ADDR
                                                    : adbkm_pkg::MOUSE_ADDR,
                           4'($urandom())};
    end else begin
      it.command = KIND_RESERVED;
    end
    return it;
  endfunction

  task automatic add_row(input adbkm_pkg::in_item_t it, input bit has_want,
                         input adbkm_pkg::out_item_t want);
    stim_row_t row;
    row.item     = it;
    row.has_want = has_want;
    row.want     = want;
    dir_rows.push_back(row);
  endtask

  // offer one item, wait for the handshake, then log its reply
  task automatic push_item(input adbkm_pkg::in_item_t it, input bit has_want,
                           input adbkm_pkg::out_item_t want);
    adbkm_pkg::out_item_t guess;
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    guess = predict_reply(it);
    expected_replies.push_back(has_want ? want : guess);
    @(negedge clk_i);
  endtask

  // window is only rewritten once the block has gone quiet
  task automatic set_window(input logic [15:0] ms);
    in_if.valid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    hold_window  = ms;
  endtask

  task automatic flag_mismatch(input string what, input adbkm_pkg::out_item_t want,
                               input adbkm_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s exp talk=%b word=%h msrq=%b ksrq=%b drop=%b", $time, what,
               want.talk, want.talk_word, want.mouse_service_request,
               want.keyboard_service_request, want.keydown_dropped,
               " got talk=%b word=%h msrq=%b ksrq=%b drop=%b",
               got.talk, got.talk_word, got.mouse_service_request,
               got.keyboard_service_request, got.keydown_dropped);
  endtask

  // result side stalls at random, except in the quiet phase
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
    end
  end

  // every reply taken is matched against the oldest one logged
  always @(posedge clk_i) begin
    adbkm_pkg::out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_replies.size() == 0) begin
        flag_mismatch("unexpected reply", '0, out_if.payload);
      end else begin
        want = expected_replies.pop_front();
        if (out_if.payload.talk !== want.talk ||
            out_if.payload.talk_word !== want.talk_word ||
            out_if.payload.mouse_service_request !== want.mouse_service_request ||
            out_if.payload.keyboard_service_request !== want.keyboard_service_request ||
            out_if.payload.keydown_dropped !== want.keydown_dropped)
          flag_mismatch("reply mismatch", want, out_if.payload);
      end
    end
  end

  initial begin
    adbkm_pkg::in_item_t odd;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    gaps_on        = 1'b1;
    clock_ms       = '0;

    // model state as after reset
    ms_pending  = 1'b0;
    ms_word     = '0;
    ms_srq      = 1'b0;
    kb_pending  = 1'b0;
    kb_word     = '0;
    kb_invalid  = 1'b0;
    kb_prev     = '0;
    kb_srq      = 1'b0;
    kb_mods     = '0;
    hold_stamp  = '0;
    hold_window = adbkm_pkg::SKIP_WINDOW_RST;

    // extremes first, then a random window and 200 ms, then back to the reset value
    window_plan[0] = 16'd0;
    window_plan[1] = 16'hFFFF;
    window_plan[2] = 16'd1;
    window_plan[3] = 16'($urandom_range(300, 20));
    window_plan[4] = 16'd200;
    window_plan[5] = adbkm_pkg::SKIP_WINDOW_RST;

    // polls with nothing pending, then the fixed registers
    add_row(host_item({adbkm_pkg::MOUSE_ADDR, adbkm_pkg::SUB_TALK0}, 32'd0), 1'b1,
            outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0}, 32'd0), 1'b1,
            outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK2}, 32'd0), 1'b1,
            outcome(1'b1, 16'h00FF, 1'b0, 1'b0, 1'b0));
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK3}, 32'd0), 1'b1,
            outcome(1'b1, adbkm_pkg::KBD_REG3_WORD, 1'b0, 1'b0, 1'b0));
    // mouse report, raised srq by a foreign poll, then read out
    add_row(mouse_item(16'hFFFF), 1'b0, '0);
    add_row(host_item({OTHER_ADDR, SUB_RESET}, 32'd0), 1'b1,
            outcome(1'b0, 16'h0000, 1'b1, 1'b0, 1'b0));
    add_row(host_item({adbkm_pkg::MOUSE_ADDR, adbkm_pkg::SUB_TALK0}, 32'd0), 1'b1,
            outcome(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    // keydown just after time zero falls in the window from reset
    add_row(kbd_item(16'h1234, 1'b0, 8'h00, 8'hFF), 1'b0, '0);
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0}, 32'd5), 1'b1,
            outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1));
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK2}, 32'd0), 1'b1,
            outcome(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    // invalid report becomes a key-up and opens the window at 1000
    add_row(kbd_item(16'hABCD, 1'b1, 8'h7F, 8'h00), 1'b0, '0);
    add_row(host_item({FAR_ADDR, SUB_RESET}, 32'd0), 1'b1,
            outcome(1'b0, 16'h0000, 1'b0, 1'b1, 1'b0));
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0}, 32'd1000), 1'b1,
            outcome(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    // one ms before and exactly at the end of the window
    add_row(kbd_item(16'h0001, 1'b0, 8'h00, 8'h5A), 1'b0, '0);
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0}, 32'd1089), 1'b1,
            outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1));
    add_row(kbd_item(16'h0002, 1'b0, 8'h00, 8'h5A), 1'b0, '0);
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0}, 32'd1090), 1'b1,
            outcome(1'b1, 16'h0002, 1'b0, 1'b0, 1'b0));
    // window opened near the top of the clock, keydown after it wraps
    add_row(kbd_item(16'h8000, 1'b1, 8'h00, 8'h81), 1'b0, '0);
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0}, 32'hFFFF_FFF0), 1'b1,
            outcome(1'b1, 16'h80FF, 1'b0, 1'b0, 1'b0));
    add_row(kbd_item(16'h0003, 1'b0, 8'h00, 8'h81), 1'b0, '0);
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK0}, 32'h0000_0010), 1'b1,
            outcome(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1));
    // a keyboard poll raises the mouse srq; other commands to the mouse, and the reserved kind, change nothing
    add_row(mouse_item(16'h0000), 1'b0, '0);
    add_row(host_item({adbkm_pkg::KBD_ADDR, adbkm_pkg::SUB_TALK3}, 32'd0), 1'b1,
            outcome(1'b1, adbkm_pkg::KBD_REG3_WORD, 1'b1, 1'b0, 1'b0));
    add_row(host_item({adbkm_pkg::MOUSE_ADDR, SUB_TALK1}, 32'd0), 1'b1,
            outcome(1'b0, 16'h0000, 1'b1, 1'b0, 1'b0));
    odd         = junk_item();
    odd.command = KIND_RESERVED;
    add_row(odd, 1'b1, outcome(1'b0, 16'h0000, 1'b1, 1'b0, 1'b0));
    add_row(host_item({adbkm_pkg::MOUSE_ADDR, adbkm_pkg::SUB_TALK0}, 32'd0), 1'b1,
            outcome(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);

    // random phases, each under its own window; one phase runs without gaps
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      set_window(window_plan[p]);
      gaps_on = (p != QUIET_PHASE);
      repeat (ITEMS_PER_PHASE) push_item(random_item(), 1'b0, '0);
    end

    in_if.valid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("adb_keyboard_mouse_responder test passed");
    end else begin
      $display("adb_keyboard_mouse_responder test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/adbkm_pkg.sv
sv/adbkm_chan_if.sv
sv/adbkm_devices.sv
sv/adb_keyboard_mouse_responder.sv
verif/adb_keyboard_mouse_responder_tb.sv
